// ----- src/stq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg: shared types and codes for the sorted timer queue
// Request, status and command codes, plus the words passed between the
// decode front, the list engine and the result queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  // fixed port widths
  localparam int ID_BITS      = 4;
  localparam int IN_TIME_BITS = 32;

  // request codes on req_type
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_ADJUST = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  // status codes on results
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ACTIVE   = 2'd1;
  localparam logic [1:0] STATUS_INACTIVE = 2'd2;

  // decoded command kinds
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_ADJUST = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;
  localparam logic [2:0] CMD_BAD_ID = 3'd4;

  // command word, front to back; tval is expiry or current time, masked
  typedef struct packed {
    logic [2:0]              kind;
    logic [ID_BITS-1:0]      id;
    logic [IN_TIME_BITS-1:0] tval;
  } cmd_t;

  // result word, back to output queue
  typedef struct packed {
    logic [1:0]         status;
    logic               expired_valid;
    logic [ID_BITS-1:0] expired_id;
    logic               last;
  } result_t;

endpackage

// ----- src/stq_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_fifo: small first-word-fall-through queue
// Register-based queue with full/empty flags; the head word is always
// visible on rd_data while empty is low.
// ----------------------------------------------------------------------------
module stq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = store[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- src/stq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_front: request decode
// Turns a request into a command word: picks the time operand, masks it
// to the configured time width and flags ids beyond the slot range.
// ----------------------------------------------------------------------------
module stq_front #(
  parameter int SLOT_USE = 16,
  parameter int TW       = 32
) (
  input  logic [1:0]                        req_type,
  input  logic [stq_pkg::ID_BITS-1:0]       timer_id,
  input  logic [stq_pkg::IN_TIME_BITS-1:0]  expiry_time,
  input  logic [stq_pkg::IN_TIME_BITS-1:0]  now_time,
  output stq_pkg::cmd_t                     cmd
);

  always_comb begin
    cmd.kind = stq_pkg::CMD_TICK;
    cmd.id   = timer_id;
    cmd.tval = '0;
    unique case (req_type)
      stq_pkg::REQ_ADD: begin
        cmd.kind           = stq_pkg::CMD_ADD;
        cmd.tval[TW-1:0]   = expiry_time[TW-1:0];
      end
      stq_pkg::REQ_ADJUST: begin
        cmd.kind           = stq_pkg::CMD_ADJUST;
        cmd.tval[TW-1:0]   = expiry_time[TW-1:0];
      end
      stq_pkg::REQ_DELETE: begin
        cmd.kind           = stq_pkg::CMD_DELETE;
      end
      stq_pkg::REQ_TICK: begin
        cmd.kind           = stq_pkg::CMD_TICK;
        cmd.tval[TW-1:0]   = now_time[TW-1:0];
      end
      default: begin
        cmd.kind           = stq_pkg::CMD_TICK;
      end
    endcase
    // timer requests naming a slot that does not exist
    if (req_type != stq_pkg::REQ_TICK && int'(timer_id) >= SLOT_USE) begin
      cmd.kind = stq_pkg::CMD_BAD_ID;
    end
  end

endmodule

// ----- src/stq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_back: ordered list engine
// Keeps the active timers in a one-read, one-write list memory sorted by expiry
// and executes add, adjust, delete and tick one list entry per cycle while results do not stall.
// ----------------------------------------------------------------------------
module stq_back #(
  parameter int SLOT_USE = 16,
  parameter int TW       = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  stq_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output stq_pkg::result_t  res
);

  localparam int AW = $clog2(SLOT_USE);
  localparam int CW = $clog2(SLOT_USE + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS    = 3'd1;
  localparam logic [2:0] S_REM    = 3'd2;
  localparam logic [2:0] S_ISTART = 3'd3;
  localparam logic [2:0] S_TICK   = 3'd4;
  localparam logic [2:0] S_TFIN   = 3'd5;

  typedef struct packed {
    logic [AW-1:0] id;
    logic [TW-1:0] expiry;
  } ent_t;

  // list memory and its ports
  ent_t          ord_mem [SLOT_USE];
  ent_t          rdata;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rd_sel;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  ent_t          wr_data;

  // control registers
  logic [2:0]          state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [SLOT_USE-1:0] active, active_next;
  logic [CW-1:0]       idx, idx_next;
  logic                found, found_next;
  logic                expiring, expiring_next;
  logic [CW-1:0]       kcnt, kcnt_next;
  logic                ins_after, ins_after_next;
  logic [AW-1:0]       pend_id, pend_id_next;
  logic [AW-1:0]       tgt_id, tgt_id_next;
  logic [TW-1:0]       tval, tval_next;
  logic [AW-1:0]       cmd_id;

  assign cmd_id = cmd.id[AW-1:0];

  // sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    active_next    = active;
    idx_next       = idx;
    found_next     = found;
    expiring_next  = expiring;
    kcnt_next      = kcnt;
    ins_after_next = ins_after;
    pend_id_next   = pend_id;
    tgt_id_next    = tgt_id;
    tval_next      = tval;
    rd_sel         = idx;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rdata;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    res.status        = stq_pkg::STATUS_OK;
    res.expired_valid = 1'b0;
    res.expired_id    = '0;
    res.last          = 1'b1;

    unique case (state)
      S_IDLE: begin
        rd_sel = '0;
        if (cmd_valid && !res_full) begin
          cmd_pop     = 1'b1;
          res_push    = 1'b1;
          tgt_id_next = cmd_id;
          tval_next   = cmd.tval[TW-1:0];
          unique case (cmd.kind)
            stq_pkg::CMD_ADD: begin
              if (active[cmd_id]) begin
                res.status = stq_pkg::STATUS_ACTIVE;
              end else begin
                active_next[cmd_id] = 1'b1;
                idx_next            = count;
                rd_sel              = count - 1'b1;
                state_next          = S_INS;
              end
            end
            stq_pkg::CMD_ADJUST: begin
              if (!active[cmd_id]) begin
                res.status = stq_pkg::STATUS_INACTIVE;
              end else begin
                idx_next       = '0;
                found_next     = 1'b0;
                ins_after_next = 1'b1;
                state_next     = S_REM;
              end
            end
            stq_pkg::CMD_DELETE: begin
              if (!active[cmd_id]) begin
                res.status = stq_pkg::STATUS_INACTIVE;
              end else begin
                active_next[cmd_id] = 1'b0;
                idx_next            = '0;
                found_next          = 1'b0;
                ins_after_next      = 1'b0;
                state_next          = S_REM;
              end
            end
            stq_pkg::CMD_TICK: begin
              // empty list answers with the no-expiry word right away
              if (count != '0) begin
                res_push      = 1'b0;
                idx_next      = '0;
                kcnt_next     = '0;
                expiring_next = 1'b1;
                state_next    = S_TICK;
              end
            end
            default: begin
              res.status = stq_pkg::STATUS_INACTIVE;
            end
          endcase
        end
      end

      // walk from the tail, shifting later expiries down one place
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        if (idx == '0 || rdata.expiry <= tval) begin
          wr_data.id     = tgt_id;
          wr_data.expiry = tval;
          count_next     = count + 1'b1;
          state_next     = S_IDLE;
        end else begin
          idx_next = idx - 1'b1;
          rd_sel   = idx - 2'd2;
        end
      end

      // walk from the head, closing the gap behind the removed id
      S_REM: begin
        rd_sel   = idx + 1'b1;
        idx_next = idx + 1'b1;
        if (found) begin
          wr_en   = 1'b1;
          wr_addr = AW'(idx - 1'b1);
        end
        if (rdata.id == tgt_id) begin
          found_next = 1'b1;
        end
        if (idx == count - 1'b1) begin
          count_next = count - 1'b1;
          if (ins_after) begin
            idx_next   = count - 1'b1;
            state_next = S_ISTART;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      // spare state so the tail read sees the last removal write
      S_ISTART: begin
        rd_sel     = idx - 1'b1;
        state_next = S_INS;
      end

      // pop expired entries, then compact the rest toward the head
      S_TICK: begin
        if (expiring && rdata.expiry <= tval) begin
          if (kcnt != '0) begin
            res_push          = !res_full;
            res.expired_valid = 1'b1;
            res.expired_id    = stq_pkg::ID_BITS'(pend_id);
            res.last          = 1'b0;
          end
          if (kcnt == '0 || !res_full) begin
            pend_id_next          = rdata.id;
            active_next[rdata.id] = 1'b0;
            kcnt_next             = kcnt + 1'b1;
            idx_next              = idx + 1'b1;
            rd_sel                = idx + 1'b1;
            if (idx == count - 1'b1) begin
              state_next = S_TFIN;
            end
          end
        end else if (kcnt == '0) begin
          res_push = !res_full;
          if (!res_full) begin
            state_next = S_IDLE;
          end
        end else begin
          expiring_next = 1'b0;
          wr_en         = 1'b1;
          wr_addr       = AW'(idx - kcnt);
          idx_next      = idx + 1'b1;
          rd_sel        = idx + 1'b1;
          if (idx == count - 1'b1) begin
            state_next = S_TFIN;
          end
        end
      end

      // final expired word carries last
      S_TFIN: begin
        if (!res_full) begin
          res_push          = 1'b1;
          res.expired_valid = 1'b1;
          res.expired_id    = stq_pkg::ID_BITS'(pend_id);
          count_next        = count - kcnt;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // keep reads inside the memory
    rd_addr = (rd_sel < CW'(SLOT_USE)) ? rd_sel[AW-1:0] : '0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      active    <= '0;
      found     <= 1'b0;
      expiring  <= 1'b0;
      kcnt      <= '0;
      ins_after <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      active    <= active_next;
      found     <= found_next;
      expiring  <= expiring_next;
      kcnt      <= kcnt_next;
      ins_after <= ins_after_next;
    end
  end

  // operands, no reset
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    pend_id <= pend_id_next;
    tgt_id  <= tgt_id_next;
    tval    <= tval_next;
  end

  // list memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ord_mem[wr_addr] <= wr_data;
    end
    rdata <= ord_mem[rd_addr];
  end

`ifndef SYNTHESIS
  // list length never exceeds the slot count
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOT_USE))
    else $error("list length beyond slot count");

  // between commands the active bits agree with the list length
  a_active_count: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> $countones(active) == int'(count))
    else $error("active bits disagree with list length");

  // list walks for add, adjust and delete emit nothing
  a_walk_silent: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS || state == S_REM || state == S_ISTART) |-> !res_push)
    else $error("result pushed during list walk");

  // closing a tick only happens after something expired
  a_tfin_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_TFIN |-> kcnt != '0)
    else $error("tick close without expired timer");
`endif

endmodule

// ----- src/sorted_timer_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue: ascending sorted timer list
// Holds up to TIMER_SLOTS timers by slot id, ordered by absolute expiry,
// and serves add, adjust, delete and tick requests through queue ports.
// ----------------------------------------------------------------------------
// Requests enter through a two-word command queue and results leave through
// a four-word result queue, so either side can stall independently. The
// list engine walks a one-read, one-write list memory one entry per cycle
// unless a result word stalls; a request occupies it for one walk of the
// list, adjust for two (remove, then reinsert), and a tick also waits on each
// stalled result word. Ids at or above the slot count (slots beyond 16 are
// unreachable through the 4-bit id) answer "not active". Times compare on
// the low TIME_BITS bits, at most 32. Reset needs no clearing pass: the active
// bits are flops and list memory contents are only used below the list length.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        req_type,
  input  logic [stq_pkg::ID_BITS-1:0]       timer_id,
  input  logic [stq_pkg::IN_TIME_BITS-1:0]  expiry_time,
  input  logic [stq_pkg::IN_TIME_BITS-1:0]  now_time,
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        status,
  output logic                              expired_valid,
  output logic [stq_pkg::ID_BITS-1:0]       expired_id,
  output logic                              last
);

  localparam int ID_SPACE = 1 << stq_pkg::ID_BITS;
  localparam int SLOT_USE = (TIMER_SLOTS < ID_SPACE) ? TIMER_SLOTS : ID_SPACE;
  localparam int TW = (TIME_BITS < stq_pkg::IN_TIME_BITS) ? TIME_BITS
                                                         : stq_pkg::IN_TIME_BITS;

  stq_pkg::cmd_t    cmd_in;
  stq_pkg::cmd_t    cmd_head;
  logic             cmd_empty;
  logic             cmd_pop;
  stq_pkg::result_t res_in;
  stq_pkg::result_t res_head;
  logic             res_push;
  logic             res_full;

  // decode
  stq_front #(
    .SLOT_USE (SLOT_USE),
    .TW       (TW)
  ) u_front (
    .req_type    (req_type),
    .timer_id    (timer_id),
    .expiry_time (expiry_time),
    .now_time    (now_time),
    .cmd         (cmd_in)
  );

  // command queue between front and back
  stq_fifo #(
    .WIDTH ($bits(stq_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  // list engine
  stq_back #(
    .SLOT_USE (SLOT_USE),
    .TW       (TW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // result queue
  stq_fifo #(
    .WIDTH ($bits(stq_pkg::result_t)),
    .DEPTH (4)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign status        = res_head.status;
  assign expired_valid = res_head.expired_valid;
  assign expired_id    = res_head.expired_id;
  assign last          = res_head.last;

endmodule
